// ----- design/constant_fold_alu_defines.svh -----
// Assertion macros shared by the constant_fold_alu RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef CONSTANT_FOLD_ALU_DEFINES_SVH
`define CONSTANT_FOLD_ALU_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CFA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define CFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/cfa_pkg.sv -----
// Types, operation codes and helpers for the constant_fold_alu block.
// Depends on nothing; used by every module of the block.
`default_nettype none

package cfa_pkg;

   localparam logic [4:0] OP_ADD = 5'd0;
   localparam logic [4:0] OP_SUB = 5'd1;
   localparam logic [4:0] OP_MUL = 5'd2;
   localparam logic [4:0] OP_DIV = 5'd3;
   localparam logic [4:0] OP_MOD = 5'd4;
   localparam logic [4:0] OP_AND = 5'd5;
   localparam logic [4:0] OP_OR  = 5'd6;
   localparam logic [4:0] OP_XOR = 5'd7;
   localparam logic [4:0] OP_SHL = 5'd8;
   localparam logic [4:0] OP_SHR = 5'd9;
   localparam logic [4:0] OP_EQ  = 5'd10;
   localparam logic [4:0] OP_NE  = 5'd11;
   localparam logic [4:0] OP_LT  = 5'd12;
   localparam logic [4:0] OP_LE  = 5'd13;
   localparam logic [4:0] OP_GT  = 5'd14;
   localparam logic [4:0] OP_GE  = 5'd15;
   localparam logic [4:0] OP_NEG = 5'd16;
   localparam logic [4:0] OP_NOT = 5'd17;

   localparam logic [1:0] SIZE_8 = 2'd3;

   localparam logic [5:0] SHIFT_MASK_WIDE   = 6'd63;
   localparam logic [5:0] SHIFT_MASK_NARROW = 6'd31;

   localparam logic [63:0] SIGNED_MIN = 64'h8000_0000_0000_0000;

   // one restoring step per quotient bit
   localparam int unsigned DIV_BITS = 64;

   // accept edge to the edge that takes the result
   localparam int unsigned LATENCY = DIV_BITS + 4;

   typedef struct packed {
      logic [4:0]  op;
      logic [63:0] a;
      logic [63:0] b;
      logic        sgn;
      logic [1:0]  size;
      logic        rsgn;
   } req_type;

   typedef struct packed {
      logic       fail;
      logic       neg_q;
      logic       neg_r;
      logic [5:0] shamt;
   } class_type;

   typedef struct packed {
      req_type   req;
      class_type cls;
   } q_type;

   typedef struct packed {
      logic        fail;
      logic [4:0]  op;
      logic [1:0]  size;
      logic        rsgn;
      logic        neg_q;
      logic        neg_r;
      logic [63:0] raw;
   } ctl_type;

   function automatic logic [63:0] fit_result(input logic [63:0] v, input logic [1:0] size,
                                               input logic rsgn);
      logic [63:0] r;
      unique case (size)
         2'd0: r = {{56{rsgn & v[7]}}, v[7:0]};
         2'd1: r = {{48{rsgn & v[15]}}, v[15:0]};
         2'd2: r = {{32{rsgn & v[31]}}, v[31:0]};
         default: r = v;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- design/cfa_front.sv -----
// Front end: takes command words, classifies them and queues them for the back end.
// Depends on cfa_pkg.
`default_nettype none

module cfa_front #(
   parameter int unsigned DEPTH = 2
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic [4:0]      req_operation,
   input  logic [63:0]     req_operand_a,
   input  logic [63:0]     req_operand_b,
   input  logic            req_operand_signed,
   input  logic [1:0]      req_result_size,
   input  logic            req_result_signed,
   output logic            q_valid,
   output cfa_pkg::q_type  q_word
);
   import cfa_pkg::*;

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   q_type         slot_ff [DEPTH];
   q_type         word_in;
   logic          push;
   logic          is_divmod;

   assign busy    = (count_ff == CW'(DEPTH));
   assign push    = start && !busy;
   assign q_valid = (count_ff != '0);
   assign q_word  = slot_ff[rd_ptr_ff];

   always_comb begin
      word_in.req.op   = req_operation;
      word_in.req.a    = req_operand_a;
      word_in.req.b    = req_operand_b;
      word_in.req.sgn  = req_operand_signed;
      word_in.req.size = req_result_size;
      word_in.req.rsgn = req_result_signed;
      is_divmod = (req_operation == OP_DIV) || (req_operation == OP_MOD);
      // flag unfoldable words up front: bad code, zero divisor, signed overflow
      word_in.cls.fail = (req_operation > OP_NOT) ||
                         (is_divmod && ((req_operand_b == '0) ||
                          (req_operand_signed && (req_operand_a == SIGNED_MIN) &&
                           (req_operand_b == '1))));
      word_in.cls.neg_q = req_operand_signed & (req_operand_a[63] ^ req_operand_b[63]);
      word_in.cls.neg_r = req_operand_signed & req_operand_a[63];
      word_in.cls.shamt = req_operand_b[5:0] &
                          ((req_result_size == SIZE_8) ? SHIFT_MASK_WIDE : SHIFT_MASK_NARROW);
   end

   // the back end drains one word every cycle
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_valid) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(push) - CW'(q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= word_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/cfa_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, control word carried along.
// Depends on cfa_pkg.
`default_nettype none

module cfa_div_pipe (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  cfa_pkg::ctl_type  in_ctl,
   input  logic [63:0]       dividend,
   input  logic [63:0]       divisor,
   output logic              out_valid,
   output cfa_pkg::ctl_type  out_ctl,
   output logic [63:0]       quotient,
   output logic [63:0]       remainder
);
   import cfa_pkg::*;

   logic        valid_ff [DIV_BITS];
   ctl_type     ctl_ff   [DIV_BITS];
   logic [63:0] rem_ff   [DIV_BITS];
   logic [63:0] dq_ff    [DIV_BITS];
   logic [63:0] dvs_ff   [DIV_BITS];

   for (genvar g = 0; g < DIV_BITS; g++) begin : g_stage
      logic        src_valid;
      ctl_type     src_ctl;
      logic [63:0] src_rem, src_dq, src_dvs;
      logic [64:0] trial;
      logic        ge;
      logic [63:0] rem_in, dq_in;

      if (g == 0) begin : g_head
         assign src_valid = in_valid;
         assign src_ctl   = in_ctl;
         assign src_rem   = '0;
         assign src_dq    = dividend;
         assign src_dvs   = divisor;
      end else begin : g_body
         assign src_valid = valid_ff[g-1];
         assign src_ctl   = ctl_ff[g-1];
         assign src_rem   = rem_ff[g-1];
         assign src_dq    = dq_ff[g-1];
         assign src_dvs   = dvs_ff[g-1];
      end

      // shift in the next dividend bit, subtract when it fits
      always_comb begin
         trial  = {src_rem, src_dq[63]};
         ge     = (trial >= {1'b0, src_dvs});
         rem_in = ge ? 64'(trial - {1'b0, src_dvs}) : trial[63:0];
         dq_in  = {src_dq[62:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else begin
            valid_ff[g] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         ctl_ff[g] <= src_ctl;
         rem_ff[g] <= rem_in;
         dq_ff[g]  <= dq_in;
         dvs_ff[g] <= src_dvs;
      end
   end

   assign out_valid = valid_ff[DIV_BITS-1];
   assign out_ctl   = ctl_ff[DIV_BITS-1];
   assign quotient  = dq_ff[DIV_BITS-1];
   assign remainder = rem_ff[DIV_BITS-1];

endmodule

`default_nettype wire

// ----- design/cfa_back.sv -----
// Back end: operand prep, split multiply, divider pipe and result fitting.
// Depends on cfa_pkg and cfa_div_pipe.
`default_nettype none

module cfa_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   input  cfa_pkg::q_type  q_word,
   output logic            rsp_strobe,
   output logic            rsp_folded,
   output logic [63:0]     rsp_value
);
   import cfa_pkg::*;

   logic        e0_valid_ff, e1_valid_ff;
   ctl_type     e0_ctl_ff, e0_ctl_in, e1_ctl_ff, e1_ctl_in;
   logic [63:0] e0_ma_ff, e0_ma_in, e0_mb_ff, e0_mb_in, e1_ma_ff, e1_mb_ff;
   logic [63:0] e0_pll_ff, e0_plh_ff, e0_phl_ff;
   logic [63:0] sa, sb, a, b;
   logic        d_valid;
   ctl_type     d_ctl;
   logic [63:0] d_quo, d_rem, res;
   logic        strobe_ff, folded_ff;
   logic [63:0] value_ff, value_in;

   // simple ops and magnitudes; the partial products follow in the register block
   always_comb begin
      a  = q_word.req.a;
      b  = q_word.req.b;
      sa = a ^ {q_word.req.sgn, 63'd0};
      sb = b ^ {q_word.req.sgn, 63'd0};
      e0_ma_in = (q_word.req.sgn && a[63]) ? 64'(-a) : a;
      e0_mb_in = (q_word.req.sgn && b[63]) ? 64'(-b) : b;
      e0_ctl_in.fail  = q_word.cls.fail;
      e0_ctl_in.op    = q_word.req.op;
      e0_ctl_in.size  = q_word.req.size;
      e0_ctl_in.rsgn  = q_word.req.rsgn;
      e0_ctl_in.neg_q = q_word.cls.neg_q;
      e0_ctl_in.neg_r = q_word.cls.neg_r;
      unique case (q_word.req.op)
         OP_ADD: e0_ctl_in.raw = a + b;
         OP_SUB: e0_ctl_in.raw = a - b;
         OP_AND: e0_ctl_in.raw = a & b;
         OP_OR:  e0_ctl_in.raw = a | b;
         OP_XOR: e0_ctl_in.raw = a ^ b;
         OP_SHL: e0_ctl_in.raw = a << q_word.cls.shamt;
         OP_SHR: e0_ctl_in.raw = q_word.req.sgn ? 64'($signed(a) >>> q_word.cls.shamt)
                                                : a >> q_word.cls.shamt;
         OP_EQ:  e0_ctl_in.raw = {63'd0, a == b};
         OP_NE:  e0_ctl_in.raw = {63'd0, a != b};
         OP_LT:  e0_ctl_in.raw = {63'd0, sa < sb};
         OP_LE:  e0_ctl_in.raw = {63'd0, sa <= sb};
         OP_GT:  e0_ctl_in.raw = {63'd0, sa > sb};
         OP_GE:  e0_ctl_in.raw = {63'd0, sa >= sb};
         OP_NEG: e0_ctl_in.raw = 64'(-a);
         OP_NOT: e0_ctl_in.raw = ~a;
         default: e0_ctl_in.raw = '0;
      endcase
   end

   // low 64 bits of the product; the high-high term drops out
   always_comb begin
      e1_ctl_in = e0_ctl_ff;
      if (e0_ctl_ff.op == OP_MUL) begin
         e1_ctl_in.raw = e0_pll_ff + {e0_plh_ff[31:0] + e0_phl_ff[31:0], 32'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e0_valid_ff <= 1'b0;
         e1_valid_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         e0_valid_ff <= q_valid;
         e1_valid_ff <= e0_valid_ff;
         strobe_ff   <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      e0_ctl_ff <= e0_ctl_in;
      e0_ma_ff  <= e0_ma_in;
      e0_mb_ff  <= e0_mb_in;
      e0_pll_ff <= 64'(q_word.req.a[31:0]) * 64'(q_word.req.b[31:0]);
      e0_plh_ff <= 64'(q_word.req.a[31:0]) * 64'(q_word.req.b[63:32]);
      e0_phl_ff <= 64'(q_word.req.a[63:32]) * 64'(q_word.req.b[31:0]);
      e1_ctl_ff <= e1_ctl_in;
      e1_ma_ff  <= e0_ma_ff;
      e1_mb_ff  <= e0_mb_ff;
      folded_ff <= !d_ctl.fail;
      value_ff  <= value_in;
   end

   cfa_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e1_valid_ff),
      .in_ctl    (e1_ctl_ff),
      .dividend  (e1_ma_ff),
      .divisor   (e1_mb_ff),
      .out_valid (d_valid),
      .out_ctl   (d_ctl),
      .quotient  (d_quo),
      .remainder (d_rem)
   );

   // fix signs, then truncate and extend
   always_comb begin
      if (d_ctl.op == OP_DIV) begin
         res = d_ctl.neg_q ? 64'(-d_quo) : d_quo;
      end else if (d_ctl.op == OP_MOD) begin
         res = d_ctl.neg_r ? 64'(-d_rem) : d_rem;
      end else begin
         res = d_ctl.raw;
      end
      value_in = d_ctl.fail ? '0 : fit_result(res, d_ctl.size, d_ctl.rsgn);
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_folded = folded_ff;
   assign rsp_value  = value_ff;

endmodule

`default_nettype wire

// ----- design/constant_fold_alu.sv -----
// Throughput: one word per cycle; the 64-stage divider pipe sets the latency.
// Every word passes the same pipeline, so results leave in acceptance order.
// busy rises only if the input queue fills, which the always-draining back end prevents.
// Reset (synchronous) empties the queue and drops all words in flight.
`default_nettype none
`include "constant_fold_alu_defines.svh"

module constant_fold_alu #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [4:0]  req_operation,
   input  logic [63:0] req_operand_a,
   input  logic [63:0] req_operand_b,
   input  logic        req_operand_signed,
   input  logic [1:0]  req_result_size,
   input  logic        req_result_signed,
   output logic        rsp_strobe,
   output logic        rsp_folded,
   output logic [63:0] rsp_value
);
   import cfa_pkg::*;

   logic  q_valid;
   q_type q_word;

   cfa_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_operation      (req_operation),
      .req_operand_a      (req_operand_a),
      .req_operand_b      (req_operand_b),
      .req_operand_signed (req_operand_signed),
      .req_result_size    (req_result_size),
      .req_result_signed  (req_result_signed),
      .q_valid            (q_valid),
      .q_word             (q_word)
   );

   cfa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_word     (q_word),
      .rsp_strobe (rsp_strobe),
      .rsp_folded (rsp_folded),
      .rsp_value  (rsp_value)
   );

   `CFA_ASSERT_NOW(a_no_backpressure, clock, reset, 1'b1, !busy, "queue filled up")
   `CFA_ASSERT_NEXT(a_push_lands, clock, reset, start && !busy, q_valid, "word lost in queue")
   `CFA_ASSERT_NOW(a_unfolded_zero, clock, reset, rsp_strobe && !rsp_folded, rsp_value == '0, "unfolded result not zero")
   `CFA_ASSERT_NOW(a_result_has_source, clock, reset, rsp_strobe, $past(start && !busy, LATENCY), "result without accepted word")

endmodule

`default_nettype wire

// ----- verif/tb_constant_fold_alu.sv -----
// Self-checking testbench for constant_fold_alu: directed and random words.
// Depends on cfa_pkg for operation codes; predicts each result in-line.
`default_nettype none

module tb_constant_fold_alu;
   import cfa_pkg::*;

   typedef struct {
      logic        folded;
      logic [63:0] value;
   } fold_result_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [4:0]  req_operation;
   logic [63:0] req_operand_a;
   logic [63:0] req_operand_b;
   logic        req_operand_signed;
   logic [1:0]  req_result_size;
   logic        req_result_signed;
   logic        rsp_strobe;
   logic        rsp_folded;
   logic [63:0] rsp_value;

   fold_result_type pending_results[$];
   int unsigned  error_count;
   int unsigned  cycle_count;
   int unsigned  idle_pct;

   localparam int unsigned CYCLE_LIMIT = 200000;

   constant_fold_alu u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b), .req_operand_signed(req_operand_signed),
      .req_result_size(req_result_size), .req_result_signed(req_result_signed),
      .rsp_strobe(rsp_strobe), .rsp_folded(rsp_folded), .rsp_value(rsp_value)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [63:0] fit_width(logic [63:0] v, logic [1:0] size, logic sx);
      logic [63:0] mask;
      int          bits;
      bits = 8 << size;
      if (bits == 64) return v;
      mask = (64'd1 << bits) - 64'd1;
      v = v & mask;
      if (sx && v[bits-1]) v = v | ~mask;
      return v;
   endfunction

   function automatic fold_result_type fold_constant(logic [4:0] op, logic [63:0] a,
                                                     logic [63:0] b, logic sgn,
                                                     logic [1:0] size, logic rsgn);
      fold_result_type res;
      logic [63:0]  r;
      logic [63:0]  ma;
      logic [63:0]  mb;
      logic [63:0]  ka;
      logic [63:0]  kb;
      logic [5:0]   sh;
      logic         ok;
      ok = 1'b1;
      r  = 64'd0;
      sh = b[5:0] & ((size == SIZE_8) ? SHIFT_MASK_WIDE : SHIFT_MASK_NARROW);
      ka = sgn ? (a ^ SIGNED_MIN) : a;
      kb = sgn ? (b ^ SIGNED_MIN) : b;
      case (op)
         OP_ADD: r = a + b;
         OP_SUB: r = a - b;
         OP_MUL: r = a * b;
         OP_DIV, OP_MOD: begin
            if (b == 64'd0) ok = 1'b0;
            else if (sgn && a == SIGNED_MIN && b == '1) ok = 1'b0;
            else if (sgn) begin
               ma = a[63] ? -a : a;
               mb = b[63] ? -b : b;
               if (op == OP_DIV) r = (a[63] ^ b[63]) ? -(ma / mb) : ma / mb;
               else r = a[63] ? -(ma % mb) : ma % mb;
            end else r = (op == OP_DIV) ? a / b : a % b;
         end
         OP_AND: r = a & b;
         OP_OR:  r = a | b;
         OP_XOR: r = a ^ b;
         OP_SHL: r = a << sh;
         OP_SHR: r = sgn ? 64'($signed(a) >>> sh) : a >> sh;
         OP_EQ:  r = 64'(a == b);
         OP_NE:  r = 64'(a != b);
         OP_LT:  r = 64'(ka < kb);
         OP_LE:  r = 64'(ka <= kb);
         OP_GT:  r = 64'(ka > kb);
         OP_GE:  r = 64'(ka >= kb);
         OP_NEG: r = -a;
         OP_NOT: r = ~a;
         default: ok = 1'b0;
      endcase
      res.folded = ok;
      res.value  = ok ? fit_width(r, size, rsgn) : 64'd0;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // hold start high for back-to-back words; drop it only for an idle gap
   task automatic send_word(logic [4:0] op, logic [63:0] a, logic [63:0] b,
                            logic sgn, logic [1:0] size, logic rsgn);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start              <= 1'b1;
      req_operation      <= op;
      req_operand_a      <= a;
      req_operand_b      <= b;
      req_operand_signed <= sgn;
      req_result_size    <= size;
      req_result_signed  <= rsgn;
      do @(posedge clock); while (busy);
      pending_results.push_back(fold_constant(op, a, b, sgn, size, rsgn));
   endtask

   task automatic quiet_input();
      start <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] random_operand();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(7))
         0: v = 64'(v[7:0]);
         1: v = -64'(v[3:0]);
         2: v = SIGNED_MIN ^ 64'(v[1:0]);
         3: v = 64'(v[31:0]);
         default: ;
      endcase
      return v;
   endfunction

   task automatic test_directed();
      logic [63:0] edges[5];
      edges = '{64'd0, 64'd1, '1, SIGNED_MIN, ~SIGNED_MIN};
      idle_pct = 0;
      for (int op = 0; op < 18; op++)
         send_word(5'(op), edges[op % 5], edges[(op + 2) % 5], op[0], 2'(op), op[1]);
      send_word(OP_DIV, 64'd7, 64'd0, 1'b0, 2'd3, 1'b0);
      send_word(OP_MOD, 64'd7, 64'd0, 1'b1, 2'd3, 1'b0);
      send_word(OP_DIV, SIGNED_MIN, '1, 1'b1, 2'd3, 1'b1);
      send_word(OP_MOD, SIGNED_MIN, '1, 1'b1, 2'd0, 1'b1);
      send_word(OP_SHL, 64'd1, 64'd63, 1'b0, 2'd3, 1'b0);
      send_word(OP_SHR, SIGNED_MIN, 64'd63, 1'b1, 2'd2, 1'b1);
      send_word(5'd31, '1, '1, 1'b1, 2'd3, 1'b1);
      quiet_input();
   endtask

   task automatic test_random(int unsigned count, int unsigned pct);
      logic [4:0] op;
      idle_pct = pct;
      repeat (count) begin
         op = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 18)) : 5'($urandom_range(17));
         send_word(op, random_operand(), random_operand(), 1'($urandom),
                   2'($urandom), 1'($urandom));
      end
      quiet_input();
   endtask

   always @(posedge clock) begin
      fold_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $display("unexpected result at cycle %0d", cycle_count);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_folded !== want.folded)
               report_mismatch("folded", 64'(rsp_folded), 64'(want.folded));
            if (rsp_value !== want.value) report_mismatch("value", rsp_value, want.value);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_constant_fold_alu: errors");
         $finish;
      end
   end

   initial begin
      cycle_count        = 0;
      error_count        = 0;
      idle_pct           = 0;
      reset              = 1'b1;
      start              = 1'b0;
      req_operation      = '0;
      req_operand_a      = '0;
      req_operand_b      = '0;
      req_operand_signed = 1'b0;
      req_result_size    = '0;
      req_result_signed  = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(420, 0);
      test_random(410, 61);
      test_random(410, 32);
      test_random(410, 0);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (error_count == 0) $display("tb_constant_fold_alu: clean");
      else $display("tb_constant_fold_alu: errors");
      $finish;
   end
endmodule

`default_nettype wire
